// ===== design/skvt_pkg.sv =====
// Shared types and codes for the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_DEC,
        RD_IDX,
        RD_INC
    } rd_sel_t;

    typedef enum logic {
        WR_MEM,
        WR_NEW
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        idx_op_t idx_op;
        cnt_op_t cnt_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    res_set;
        status_t res_status;
        logic    res_found;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  idx_zero;
        logic  idx_at_end;
        logic  idx_last;
        logic  greater;
        logic  match;
    } sts_t;

endpackage
`default_nettype wire

// ===== design/skvt_ctrl.sv =====
// Controller state machine for the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none
module skvt_ctrl
    import skvt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd.load       = 1'b0;
        cmd.idx_op     = IDX_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.rd_en      = 1'b0;
        cmd.rd_sel     = RD_IDX;
        cmd.wr_en      = 1'b0;
        cmd.wr_sel     = WR_MEM;
        cmd.res_set    = 1'b0;
        cmd.res_status = ST_OK;
        cmd.res_found  = 1'b0;
        cmd.out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.kind)
                    KIND_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            state_next = S_INS_RD;
                        end
                    end
                    KIND_REMOVE, KIND_FIND:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (sts.idx_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_NEW;
                    cmd.cnt_op  = CNT_INC;
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DEC;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.greater)
                begin
                    cmd.wr_sel = WR_MEM;
                    cmd.idx_op = IDX_DEC;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.wr_sel  = WR_NEW;
                    cmd.cnt_op  = CNT_INC;
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.idx_at_end)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_MISSING;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (!sts.match)
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SCAN_RD;
                end
                else if (sts.kind == KIND_FIND)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_SHF_RD;
                end
            end
            S_SHF_RD:
            begin
                if (sts.idx_last)
                begin
                    cmd.cnt_op  = CNT_DEC;
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_INC;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_MEM;
                cmd.idx_op = IDX_INC;
                state_next = S_SHF_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/skvt_dp.sv =====
// Datapath of the sorted key/value table: entry memories, index, count and result.
`timescale 1ns / 1ps
`default_nettype none
module skvt_dp
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         kind,
    input  wire logic signed [31:0] search_key,
    input  wire logic signed [31:0] entry_value,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    output logic [1:0]              status,
    output logic signed [31:0]      found_value,
    output logic [6:0]              entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] key_mem [CAPACITY];
    logic signed [31:0] val_mem [CAPACITY];

    kind_t              kind_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] rd_key_reg;
    logic signed [31:0] rd_val_reg;
    status_t            res_status_reg;
    logic signed [31:0] res_found_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] found_value_reg;
    logic [6:0]         entry_count_reg;

    logic [CW-1:0]      rd_idx;
    logic [CW:0]        idx_plus;
    logic signed [31:0] wr_key;
    logic signed [31:0] wr_val;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_DEC:  rd_idx = idx_reg - CW'(1);
            RD_INC:  rd_idx = idx_reg + CW'(1);
            default: rd_idx = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_COUNT: idx_next = count_reg;
            IDX_ZERO:  idx_next = '0;
            IDX_DEC:   idx_next = idx_reg - CW'(1);
            IDX_INC:   idx_next = idx_reg + CW'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    assign wr_key = (cmd.wr_sel == WR_NEW) ? key_reg : rd_key_reg;
    assign wr_val = (cmd.wr_sel == WR_NEW) ? val_reg : rd_val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[idx_reg[AW-1:0]] <= wr_key;
            val_mem[idx_reg[AW-1:0]] <= wr_val;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg <= key_mem[rd_idx[AW-1:0]];
            rd_val_reg <= val_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(kind);
            key_reg  <= search_key;
            val_reg  <= entry_value;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found ? rd_val_reg : 32'sd0;
        end
        if (cmd.out_load)
        begin
            status_reg      <= res_status_reg;
            found_value_reg <= res_found_reg;
            entry_count_reg <= 7'(count_reg);
        end
    end

    assign idx_plus = {1'b0, idx_reg} + (CW + 1)'(1);

    assign sts.kind       = kind_reg;
    assign sts.full       = (count_reg == CW'(CAPACITY));
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.idx_at_end = (idx_reg >= count_reg);
    assign sts.idx_last   = (idx_plus >= {1'b0, count_reg});
    assign sts.greater    = (rd_key_reg > key_reg);
    assign sts.match      = (rd_key_reg == key_reg);

    assign status      = status_reg;
    assign found_value = found_value_reg;
    assign entry_count = entry_count_reg;

endmodule
`default_nettype wire

// ===== design/sorted_key_value_table_top.sv =====
// Top level of the sorted key/value table.
//
// Holds up to CAPACITY signed key/value entries in ascending key order in a single-port
// memory pair with registered read, so each entry the operation visits takes a read state
// followed by a compare or write state. An insert walks down from the top, moving every
// entry with a greater key up by one, and writes the new entry into the gap. A find scans
// from the bottom to the match or to the entry count. A remove scans to the match and then
// closes the gap by moving every entry above it down by one. An insert into a full table
// or an unused kind code finishes without visiting any entry. The longest operations are
// a remove or a missed find over a full table.
// One operation is in flight at a time; the next input beat is taken once the result sits
// in the output register, even while that result is still stalled. The memories need no
// clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_value_table_top
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic signed [31:0] search_key,
    input  wire logic signed [31:0] entry_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      found_value,
    output logic [6:0]              entry_count
);

    cmd_t cmd;
    sts_t sts;

    skvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    skvt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .search_key  (search_key),
        .entry_value (entry_value),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .found_value (found_value),
        .entry_count (entry_count)
    );

endmodule
`default_nettype wire
